// ===== hdl/sgrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrs_pkg - shared definitions for the reflect-edge smoothing filter
// Field widths, derived datapath widths, opcodes and the MAC control bundle.
// ----------------------------------------------------------------------------
package sgrs_pkg;

    // Core sizes
    localparam int MAX_WINDOW  = 31;
    localparam int SAMPLE_BITS = 32;
    localparam int COEF_BITS   = 18;
    localparam int FRAC_BITS   = 16;

    // Half-window register
    localparam int HW_BITS  = 4;
    localparam int HW_RESET = 2;
    localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;

    // Sample ring buffer: power-of-two depth above the largest window
    localparam int PTR_W      = $clog2(MAX_WINDOW + 1);
    localparam int SBUF_DEPTH = 1 << PTR_W;

    // Coefficient table
    localparam int CIDX_BITS = 5;
    localparam int CADDR_W   = $clog2(MAX_WINDOW);

    // Datapath widths: reflected operand, product, accumulator, rounded sum
    localparam int OP_W   = SAMPLE_BITS + 2;
    localparam int PROD_W = OP_W + COEF_BITS;
    localparam int ACC_W  = PROD_W + PTR_W;
    localparam int RND_W  = ACC_W - FRAC_BITS;

    // Cycles from the last tap issue until the rounded sum is registered
    localparam int DRAIN_CYC = 4;
    localparam int DCNT_W    = $clog2(DRAIN_CYC);

    // Stream and register port widths
    localparam int S_TDATA_W  = ((CIDX_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Opcodes (carried on s_tuser)
    localparam logic OPC_LOAD   = 1'b0;
    localparam logic OPC_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [PADDR_W-3:0] REG_HALF_WINDOW = '0;

    // Per-cycle control for the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;    // tap read issued this cycle
        logic clear;    // first tap of an output: restart the accumulator
        logic reflect;  // tap uses 2*edge - sample
    } mac_ctrl_t;

endpackage

// ===== hdl/sgrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrs_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sgrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sgrs_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrs_mac - shared tap multiply-accumulate unit
// Forms the (optionally reflected) operand, multiplies by the coefficient,
// accumulates, rounds half up to the sample grid and saturates.
// ----------------------------------------------------------------------------
module sgrs_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sgrs_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [sgrs_pkg::SAMPLE_BITS-1:0] edge_value,
    input  logic signed [sgrs_pkg::SAMPLE_BITS-1:0] samp_rdata,
    input  logic signed [sgrs_pkg::COEF_BITS-1:0]   coef_rdata,
    output logic signed [sgrs_pkg::SAMPLE_BITS-1:0] result
);

    localparam int SB = sgrs_pkg::SAMPLE_BITS;

    logic                                    iss_d_reg;
    logic                                    refl_d_reg;
    logic                                    va_reg;
    logic                                    vb_reg;
    logic signed [sgrs_pkg::OP_W-1:0]        opnd_reg;
    logic signed [sgrs_pkg::COEF_BITS-1:0]   coef_q_reg;
    logic signed [sgrs_pkg::PROD_W-1:0]      prod_reg;
    logic signed [sgrs_pkg::ACC_W-1:0]       acc_reg;
    logic signed [sgrs_pkg::RND_W-1:0]       rnd_reg;

    logic signed [sgrs_pkg::OP_W-1:0]        edge2;
    logic signed [sgrs_pkg::OP_W-1:0]        samp_ext;
    logic signed [sgrs_pkg::OP_W-1:0]        opnd;
    logic signed [sgrs_pkg::ACC_W-1:0]       prod_ext;
    logic signed [sgrs_pkg::ACC_W-1:0]       rsum;
    logic                                    in_range;

    // Tap flags follow the RAM read latency
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_d_reg <= 1'b0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end else begin
            iss_d_reg <= ctrl.issue;
            va_reg    <= iss_d_reg;
            vb_reg    <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        refl_d_reg <= ctrl.reflect;
    end

    // Operand: sample, or point reflection about the edge sample
    assign edge2    = {edge_value[SB-1], edge_value, 1'b0};
    assign samp_ext = {{2{samp_rdata[SB-1]}}, samp_rdata};
    assign opnd     = refl_d_reg ? (edge2 - samp_ext) : samp_ext;

    always_ff @(posedge aclk) begin
        if (iss_d_reg) begin
            opnd_reg   <= opnd;
            coef_q_reg <= coef_rdata;
        end
    end

    // Product stage
    always_ff @(posedge aclk) begin
        prod_reg <= opnd_reg * coef_q_reg;
    end

    assign prod_ext = {{(sgrs_pkg::ACC_W - sgrs_pkg::PROD_W){prod_reg[sgrs_pkg::PROD_W-1]}},
                       prod_reg};

    // Accumulator, restarted on the first tap of each output
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (vb_reg) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    // Round half up, then drop the fraction bits
    assign rsum = acc_reg + sgrs_pkg::ACC_W'(1 << (sgrs_pkg::FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        rnd_reg <= rsum[sgrs_pkg::ACC_W-1:sgrs_pkg::FRAC_BITS];
    end

    // Saturate to the sample range
    assign in_range = (rnd_reg[sgrs_pkg::RND_W-1:SB-1] == '0) ||
                      (rnd_reg[sgrs_pkg::RND_W-1:SB-1] == '1);

    always_comb begin
        if (in_range) begin
            result = rnd_reg[SB-1:0];
        end else if (rnd_reg[sgrs_pkg::RND_W-1]) begin
            result = {1'b1, {(SB-1){1'b0}}};
        end else begin
            result = {1'b0, {(SB-1){1'b1}}};
        end
    end

endmodule

// ===== hdl/savitzky_golay_reflect_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savitzky_golay_reflect_smoother - windowed smoother with reflected edges
// Each filtered output issues W = 2*half_window+1 taps (half_window 0 acts
// as 1) through one shared multiplier, drains the MAC pipeline and loads
// the output slot, waiting while it is full. A short channel reads and loads
// each sample in turn; loads and quiet samples leave the block idle.
// Reset: synchronous, active low; clears control, half_window returns to 2;
// coefficient and sample RAMs are not cleared.
// ----------------------------------------------------------------------------
module savitzky_golay_reflect_smoother (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [4:0] coef_index, [22:5] coef_value, [54:23] sample_value
    input  logic [sgrs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,   // end_of_channel
    input  logic                               s_tuser,   // [0] opcode
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] smoothed_value
    output logic [sgrs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,   // channel_done
    // [0] passed_through, [1] last_in_run
    output logic [1:0]                         m_tuser,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sgrs_pkg::PADDR_W-1:0]       paddr,
    input  logic [sgrs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sgrs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int PW = sgrs_pkg::PTR_W;
    localparam int SB = sgrs_pkg::SAMPLE_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TAPS  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_OUT   = 6'b001000,
        ST_PREAD = 6'b010000,
        ST_POUT  = 6'b100000
    } state_t;

    state_t                             st_reg, st_next;
    logic [sgrs_pkg::HW_BITS-1:0]       hw_reg, hw_next;
    logic [PW-1:0]                      cnt_reg, cnt_next;
    logic [PW-1:0]                      wp_reg, wp_next;
    logic [PW-1:0]                      base_reg, base_next;
    logic [PW-1:0]                      r_reg, r_next;
    logic [PW-1:0]                      j_reg, j_next;
    logic [PW-1:0]                      last_reg, last_next;
    logic [sgrs_pkg::DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic                               start_reg, start_next;
    logic                               end_reg, end_next;
    logic [SB-1:0]                      first_reg, first_next;
    logic [SB-1:0]                      x_reg, x_next;
    logic                               mv_reg, mv_next;
    logic [SB-1:0]                      md_reg, md_next;
    logic                               ml_reg, ml_next;
    logic [1:0]                         mu_reg, mu_next;

    // Input fields
    logic                               in_opcode;
    logic [sgrs_pkg::CIDX_BITS-1:0]     in_coef_idx;
    logic [sgrs_pkg::COEF_BITS-1:0]     in_coef_val;
    logic [SB-1:0]                      in_sample;

    logic                               s_accept;
    logic                               cfg_we;
    logic                               out_free;
    logic                               out_load;
    logic                               run_last;

    logic [sgrs_pkg::HW_BITS-1:0]       h_eff;
    logic [PW-1:0]                      w_cur;
    logic [PW:0]                        w_ext;
    logic [PW:0]                        h_ext;
    logic [PW-1:0]                      c_cur;
    logic [PW:0]                        c_plus;
    logic [PW-1:0]                      cnt_after;

    logic [PW:0]                        e_idx;
    logic [PW:0]                        l_idx;
    logic                               refl;
    logic [PW-1:0]                      tap_addr;

    logic                               samp_we;
    logic                               samp_re;
    logic [PW-1:0]                      samp_raddr;
    logic [SB-1:0]                      samp_rdata;
    logic                               coef_we;
    logic [sgrs_pkg::COEF_BITS-1:0]     coef_rdata;
    logic [SB-1:0]                      edge_value;
    logic [SB-1:0]                      mac_result;
    sgrs_pkg::mac_ctrl_t                mac_ctrl;

    assign in_opcode   = s_tuser;
    assign in_coef_idx = s_tdata[sgrs_pkg::CIDX_BITS-1:0];
    assign in_coef_val = s_tdata[sgrs_pkg::CIDX_BITS +: sgrs_pkg::COEF_BITS];
    assign in_sample   = s_tdata[sgrs_pkg::CIDX_BITS + sgrs_pkg::COEF_BITS +: SB];

    assign s_tready = (st_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite &&
                    (paddr[sgrs_pkg::PADDR_W-1:2] == sgrs_pkg::REG_HALF_WINDOW);
    assign prdata = (paddr[sgrs_pkg::PADDR_W-1:2] == sgrs_pkg::REG_HALF_WINDOW) ?
                    sgrs_pkg::APB_DATA_W'(hw_reg) : '0;

    // Effective half window and window length
    always_comb begin
        if (hw_reg == '0) begin
            h_eff = sgrs_pkg::HW_BITS'(1);
        end else if (int'(hw_reg) > sgrs_pkg::HALF_MAX) begin
            h_eff = sgrs_pkg::HW_BITS'(sgrs_pkg::HALF_MAX);
        end else begin
            h_eff = hw_reg;
        end
    end

    assign w_cur     = PW'({h_eff, 1'b1});
    assign w_ext     = {1'b0, w_cur};
    assign h_ext     = (PW + 1)'(h_eff);
    assign c_cur     = (cnt_reg > w_cur) ? w_cur : cnt_reg;
    assign c_plus    = {1'b0, c_cur} + (PW + 1)'(1);
    assign cnt_after = (c_plus < w_ext) ? c_plus[PW-1:0] : w_cur;

    // Tap to window index: reflect before the start or past the end
    assign e_idx = {1'b0, r_reg} + {1'b0, j_reg};

    always_comb begin
        refl  = 1'b0;
        l_idx = e_idx;
        if (start_reg) begin
            if (e_idx < h_ext) begin
                refl  = 1'b1;
                l_idx = h_ext - e_idx;
            end else begin
                l_idx = e_idx - h_ext;
            end
        end else if (e_idx >= w_ext) begin
            refl  = 1'b1;
            l_idx = (w_ext << 1) - (PW + 1)'(2) - e_idx;
        end
    end

    assign tap_addr = base_reg + l_idx[PW-1:0];

    // Memory ports
    assign samp_we    = s_accept && (in_opcode == sgrs_pkg::OPC_SAMPLE);
    assign samp_re    = (st_reg == ST_TAPS) || (st_reg == ST_PREAD);
    assign samp_raddr = (st_reg == ST_PREAD) ? (base_reg + r_reg) : tap_addr;
    assign coef_we    = s_accept && (in_opcode == sgrs_pkg::OPC_LOAD) &&
                        (int'(in_coef_idx) < sgrs_pkg::MAX_WINDOW);

    sgrs_ram #(
        .WIDTH (SB),
        .DEPTH (sgrs_pkg::SBUF_DEPTH)
    ) u_samp_ram (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (wp_reg),
        .wdata (in_sample),
        .re    (samp_re),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    sgrs_ram #(
        .WIDTH (sgrs_pkg::COEF_BITS),
        .DEPTH (sgrs_pkg::MAX_WINDOW)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (sgrs_pkg::CADDR_W'(in_coef_idx)),
        .wdata (in_coef_val),
        .re    (mac_ctrl.issue),
        .raddr (j_reg[sgrs_pkg::CADDR_W-1:0]),
        .rdata (coef_rdata)
    );

    // Shared multiply-accumulate
    assign mac_ctrl.issue   = (st_reg == ST_TAPS);
    assign mac_ctrl.clear   = (st_reg == ST_TAPS) && (j_reg == '0);
    assign mac_ctrl.reflect = refl;
    assign edge_value       = start_reg ? first_reg : x_reg;

    sgrs_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mac_ctrl),
        .edge_value (edge_value),
        .samp_rdata (samp_rdata),
        .coef_rdata (coef_rdata),
        .result     (mac_result)
    );

    // Output slot
    assign out_free = !mv_reg || m_tready;
    assign run_last = (r_reg == last_reg);
    assign out_load = ((st_reg == ST_OUT) || (st_reg == ST_POUT)) && out_free;

    // Sequencer
    always_comb begin
        st_next    = st_reg;
        hw_next    = hw_reg;
        cnt_next   = cnt_reg;
        wp_next    = wp_reg;
        base_next  = base_reg;
        r_next     = r_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        dcnt_next  = dcnt_reg;
        start_next = start_reg;
        end_next   = end_reg;
        first_next = first_reg;
        x_next     = x_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        mu_next    = mu_reg;

        // Register write abandons the current channel
        if (cfg_we) begin
            hw_next  = pwdata[sgrs_pkg::HW_BITS-1:0];
            cnt_next = '0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (s_accept && (in_opcode == sgrs_pkg::OPC_SAMPLE)) begin
                    wp_next    = wp_reg + PW'(1);
                    base_next  = wp_reg + PW'(1) - cnt_after;
                    x_next     = in_sample;
                    r_next     = '0;
                    j_next     = '0;
                    end_next   = s_tlast;
                    start_next = 1'b0;
                    cnt_next   = s_tlast ? '0 : cnt_after;
                    if (c_cur == '0) begin
                        first_next = in_sample;
                    end
                    if (s_tlast) begin
                        if (c_plus < w_ext) begin
                            // short channel: pass samples through
                            last_next = c_cur;
                            st_next   = ST_PREAD;
                        end else begin
                            last_next = PW'(h_eff);
                            st_next   = ST_TAPS;
                        end
                    end else if (c_plus == w_ext - (PW + 1)'(1)) begin
                        // start of channel: first h outputs
                        start_next = 1'b1;
                        last_next  = PW'(h_eff) - PW'(1);
                        st_next    = ST_TAPS;
                    end else if (c_plus >= w_ext) begin
                        last_next = '0;
                        st_next   = ST_TAPS;
                    end
                end
            end
            ST_TAPS: begin
                j_next = j_reg + PW'(1);
                if (j_reg == w_cur - PW'(1)) begin
                    j_next    = '0;
                    dcnt_next = '0;
                    st_next   = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                dcnt_next = dcnt_reg + sgrs_pkg::DCNT_W'(1);
                if (dcnt_reg == sgrs_pkg::DCNT_W'(sgrs_pkg::DRAIN_CYC - 1)) begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = mac_result;
                    ml_next = end_reg && run_last;
                    mu_next = {run_last, 1'b0};
                    if (run_last) begin
                        st_next = ST_IDLE;
                    end else begin
                        r_next  = r_reg + PW'(1);
                        st_next = ST_TAPS;
                    end
                end
            end
            ST_PREAD: begin
                st_next = ST_POUT;
            end
            ST_POUT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = samp_rdata;
                    ml_next = end_reg && run_last;
                    mu_next = {run_last, 1'b1};
                    if (run_last) begin
                        st_next = ST_IDLE;
                    end else begin
                        r_next  = r_reg + PW'(1);
                        st_next = ST_PREAD;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            hw_reg   <= sgrs_pkg::HW_BITS'(sgrs_pkg::HW_RESET);
            cnt_reg  <= '0;
            wp_reg   <= '0;
            r_reg    <= '0;
            j_reg    <= '0;
            dcnt_reg <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            hw_reg   <= hw_next;
            cnt_reg  <= cnt_next;
            wp_reg   <= wp_next;
            r_reg    <= r_next;
            j_reg    <= j_next;
            dcnt_reg <= dcnt_next;
            mv_reg   <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        base_reg  <= base_next;
        last_reg  <= last_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        first_reg <= first_next;
        x_reg     <= x_next;
        md_reg    <= md_next;
        ml_reg    <= ml_next;
        mu_reg    <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = sgrs_pkg::M_TDATA_W'(md_reg);
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

`ifndef SYNTHESIS
    a_idle_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mac_ctrl.issue)
        else $error("tap issued while accepting requests");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= w_cur)
        else $error("buffered sample count exceeds window");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && run_last) |=> (st_reg == ST_IDLE))
        else $error("sequencer busy after last result of request");

    a_out_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg == ST_OUT) && !$past(st_reg == ST_OUT)) |-> $past(st_reg == ST_DRAIN))
        else $error("result taken before MAC pipeline drained");
`endif

endmodule
